// ===== hdl/mhpq_pkg.sv =====
package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;

    typedef enum logic [0:0] {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [DATA_W-1:0]   value;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   min_value;
        status_t                    status;
        logic [COUNT_W-1:0]         count_after;
    } out_word_t;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                       ins;
        logic                       ext;
        logic signed [DATA_W-1:0]   value;
        logic [CNT_W-1:0]           count;
    } cmd_t;

endpackage

// ===== hdl/mhpq_cell.sv =====
module mhpq_cell (
    input  logic                                 clk,
    input  logic [mhpq_pkg::IDX_W-1:0]           idx,
    input  mhpq_pkg::cmd_t                       cmd,
    input  logic signed [mhpq_pkg::DATA_W-1:0]   left_val,
    input  logic                                 left_gt,
    input  logic signed [mhpq_pkg::DATA_W-1:0]   right_val,
    output logic signed [mhpq_pkg::DATA_W-1:0]   val,
    output logic                                 gt
);

    logic signed [mhpq_pkg::DATA_W-1:0] val_reg;
    logic signed [mhpq_pkg::DATA_W-1:0] val_next;
    logic                               occupied;
    logic                               at_end;

    assign occupied = mhpq_pkg::CNT_W'(idx) < cmd.count;
    assign at_end   = mhpq_pkg::CNT_W'(idx) == cmd.count;
    // Flag an occupied entry that must move right to make room for the new word.
    assign gt       = occupied && (val_reg > cmd.value);
    assign val      = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins)
        begin
            if (left_gt)
                val_next = left_val;
            else if (gt || at_end)
                val_next = cmd.value;
        end
        else if (cmd.ext)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== hdl/mhpq_ctrl.sv =====
module mhpq_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mhpq_pkg::in_word_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mhpq_pkg::out_word_t                  out_data,
    input  logic signed [mhpq_pkg::DATA_W-1:0]   head_val,
    output mhpq_pkg::cmd_t                       cmd
);

    logic [mhpq_pkg::CNT_W-1:0] count_reg;
    logic [mhpq_pkg::CNT_W-1:0] count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    mhpq_pkg::out_word_t        out_reg;
    mhpq_pkg::out_word_t        out_next;
    logic                       accept;
    logic                       full;
    logic                       empty;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full      = count_reg == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY);
    assign empty     = count_reg == '0;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cmd.ins        = 1'b0;
        cmd.ext        = 1'b0;
        cmd.value      = in_data.value;
        cmd.count      = count_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            out_valid_next     = 1'b1;
            out_next.min_value = '0;
            unique case (in_data.opcode)
                mhpq_pkg::OP_INSERT:
                begin
                    if (full)
                        out_next.status = mhpq_pkg::ST_FULL;
                    else
                    begin
                        cmd.ins         = 1'b1;
                        count_next      = count_reg + mhpq_pkg::CNT_W'(1);
                        out_next.status = mhpq_pkg::ST_INSERTED;
                    end
                end
                mhpq_pkg::OP_EXTRACT:
                begin
                    if (empty)
                        out_next.status = mhpq_pkg::ST_EMPTY;
                    else
                    begin
                        cmd.ext            = 1'b1;
                        count_next         = count_reg - mhpq_pkg::CNT_W'(1);
                        out_next.min_value = head_val;
                        out_next.status    = mhpq_pkg::ST_EXTRACTED;
                    end
                end
                default:
                begin
                    out_next.status = mhpq_pkg::ST_EMPTY;
                end
            endcase
            out_next.count_after = mhpq_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.opcode == mhpq_pkg::OP_INSERT && full)
        |=> (out_reg.status == mhpq_pkg::ST_FULL && count_reg == $past(count_reg)))
        else $error("insert into full queue changed state");

    a_extract_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.opcode == mhpq_pkg::OP_EXTRACT && !empty)
        |=> (out_reg.min_value == $past(head_val)
             && out_reg.status == mhpq_pkg::ST_EXTRACTED))
        else $error("extract did not return head of row");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins && cmd.ext))
        else $error("insert and extract issued together");

endmodule

// ===== hdl/min_heap_priority_queue.sv =====
// A result word appears in the output register in the cycle after its input word is taken.
// Throughput: one word per cycle unless a result is held; all cells compare and shift at once.
// The output register holds a result while out_ready is low; in_ready stays high while it drains.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending result word.
// Cell contents are not cleared; only cells below the entry count are ever observed.
module min_heap_priority_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mhpq_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mhpq_pkg::out_word_t  out_data
);

    // The queue is kept as a sorted row of cells, smallest at cell 0. Every
    // extract returns the same minimum a binary heap would, so the result
    // stream matches a heap-based queue word for word.
    //
    // Insert: each occupied cell holding a value strictly larger than the
    // new word raises gt. A cell whose left neighbor raised gt takes the
    // neighbor's value (shift right); the first cell that is larger, or the
    // first free cell, takes the new word.
    //
    // Extract: cell 0 goes out through the controller and every cell takes
    // its right neighbor's value (shift left).

    mhpq_pkg::cmd_t                       cmd;
    logic signed [mhpq_pkg::DATA_W-1:0]   cell_val [mhpq_pkg::CAPACITY];
    logic                                 cell_gt  [mhpq_pkg::CAPACITY];

    // Handshake, entry count, status and output register.
    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .head_val  (cell_val[0]),
        .cmd       (cmd)
    );

    // Row of cells; the ends see a zero neighbor that never raises gt.
    for (genvar i = 0; i < mhpq_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [mhpq_pkg::DATA_W-1:0] left_val;
        logic                               left_gt;
        logic signed [mhpq_pkg::DATA_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_val = cell_val[i-1];
            assign left_gt  = cell_gt[i-1];
        end

        if (i == mhpq_pkg::CAPACITY - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_inner_right
            assign right_val = cell_val[i+1];
        end

        mhpq_cell u_cell (
            .clk       (clk),
            .idx       (mhpq_pkg::IDX_W'(i)),
            .cmd       (cmd),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (cell_val[i]),
            .gt        (cell_gt[i])
        );
    end

endmodule

// ===== test/min_heap_priority_queue_tb.sv =====
module min_heap_priority_queue_tb;

    // Quiet cycles (no word moved on either side) before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to keep watching the output once every expected word has come back.
    localparam int DRAIN_CYCLES = 20;

    // Shadow of the queue: a software binary min-heap kept in step with the
    // block. Every accepted request word is applied here and the reply it must
    // produce is queued; every reply word the block hands out is matched against
    // the oldest queued one.
    class min_heap_shadow;
        logic signed [mhpq_pkg::DATA_W-1:0] slots [mhpq_pkg::CAPACITY];
        int unsigned                        fill;
        int unsigned                        peak;
        mhpq_pkg::out_word_t                due_replies [$];
        int                                 errors;
        int                                 replies_seen;
        int                                 inserts;
        int                                 full_refusals;
        int                                 extracts;
        int                                 empty_refusals;

        function void bubble_up(int unsigned pos);
            int unsigned                        up;
            logic signed [mhpq_pkg::DATA_W-1:0] t;
            while (pos != 0)
            begin
                up = (pos - 1) / 2;
                if (!(slots[pos] < slots[up]))
                    break;
                t          = slots[pos];
                slots[pos] = slots[up];
                slots[up]  = t;
                pos        = up;
            end
        endfunction

        function void sink_down(int unsigned pos);
            int unsigned                        lc;
            int unsigned                        rc;
            int unsigned                        best;
            logic signed [mhpq_pkg::DATA_W-1:0] t;
            while (1)
            begin
                lc   = 2 * pos + 1;
                rc   = 2 * pos + 2;
                best = pos;
                if (lc < fill && slots[lc] < slots[best])
                    best = lc;
                if (rc < fill && slots[rc] < slots[best])
                    best = rc;
                if (best == pos)
                    break;
                t           = slots[pos];
                slots[pos]  = slots[best];
                slots[best] = t;
                pos         = best;
            end
        endfunction

        function void note_request(mhpq_pkg::in_word_t w);
            mhpq_pkg::out_word_t r;
            r           = '0;
            r.min_value = '0;
            if (w.opcode == mhpq_pkg::OP_INSERT)
            begin
                inserts++;
                if (fill >= mhpq_pkg::CAPACITY)
                begin
                    r.status = mhpq_pkg::ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    slots[fill] = w.value;
                    fill++;
                    bubble_up(fill - 1);
                    r.status = mhpq_pkg::ST_INSERTED;
                end
            end
            else
            begin
                extracts++;
                if (fill == 0)
                begin
                    r.status = mhpq_pkg::ST_EMPTY;
                    empty_refusals++;
                end
                else
                begin
                    r.min_value = slots[0];
                    fill--;
                    // Last entry out: nothing left to sift.
                    if (fill != 0)
                    begin
                        slots[0] = slots[fill];
                        sink_down(0);
                    end
                    r.status = mhpq_pkg::ST_EXTRACTED;
                end
            end
            if (fill > peak)
                peak = fill;
            r.count_after = mhpq_pkg::COUNT_W'(fill);
            due_replies   = {due_replies, r};
        endfunction

        function void check_reply(mhpq_pkg::out_word_t got);
            mhpq_pkg::out_word_t want;
            replies_seen++;
            if (due_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply word, expected none: min %0d status %0d count %0d",
                         $time, got.min_value, got.status, got.count_after);
                return;
            end
            want = due_replies.pop_front();
            if (got.min_value !== want.min_value || got.status !== want.status ||
                got.count_after !== want.count_after)
            begin
                errors++;
                // Fields shown as min/status/count.
                $display("%0t: reply %0d mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                         $time, replies_seen, want.min_value, want.status,
                         want.count_after, got.min_value, got.status, got.count_after);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mhpq_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    mhpq_pkg::out_word_t out_data;

    min_heap_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    min_heap_shadow shadow;

    // Idle percentages for each side; the main sequence changes them per phase.
    int send_gap_pct = 31;
    int recv_gap_pct = 58;
    // Long receiver hold-off requested by the main sequence, counted down below.
    int recv_hold    = 0;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: drop ready at random, or hold it low for a whole requested stretch
    // so the output register backs up and the block stalls its input.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (recv_hold > 0)
            begin
                out_ready <= 1'b0;
                recv_hold--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Take every reply word the block hands out. Values sampled here are the
    // ones from just before the edge, so ordering within the step does not matter.
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
            shadow.check_reply(out_data);
    end

    // Watchdog: abort if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) ||
            (out_valid === 1'b1 && out_ready === 1'b1))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("min_heap_priority_queue_tb NOT OK");
                $finish;
            end
        end
    end

    // Offer one request word, after a random idle gap; return at the edge where
    // it is taken. Must be entered at a rising edge.
    task automatic send_word(mhpq_pkg::opcode_t op, logic signed [mhpq_pkg::DATA_W-1:0] v);
        mhpq_pkg::in_word_t w;
        w.opcode = op;
        w.value  = v;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        shadow.note_request(w);
    endtask

    // Mostly full-range values, with clusters of small ones to force ties and
    // the two's-complement extremes.
    function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(5))
            0: pick_value = $signed(32'($urandom_range(16))) - 8;
            1:
            begin
                case ($urandom_range(3))
                    0: pick_value = 32'sh8000_0000;
                    1: pick_value = 32'sh7fff_ffff;
                    2: pick_value = 32'sh0000_0000;
                    default: pick_value = -32'sd1;
                endcase
            end
            default: pick_value = $urandom;
        endcase
    endfunction

    // Send n words, inserting with the given percentage and extracting otherwise.
    // Extract words carry random junk in the value field, which must be ignored.
    task automatic run_mix(int n, int insert_pct);
        repeat (n)
        begin
            if ($urandom_range(99) < insert_pct)
                send_word(mhpq_pkg::OP_INSERT, pick_value());
            else
                send_word(mhpq_pkg::OP_EXTRACT, $urandom);
        end
    endtask

    initial
    begin
        shadow   = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extract from an empty queue, the extremes and duplicates,
        // alternating bit patterns, then drain in order down to the last entry.
        send_word(mhpq_pkg::OP_EXTRACT, 32'sh1234_5678);
        send_word(mhpq_pkg::OP_INSERT, 32'sh0000_0000);
        send_word(mhpq_pkg::OP_INSERT, 32'sh7fff_ffff);
        send_word(mhpq_pkg::OP_INSERT, 32'sh8000_0000);
        send_word(mhpq_pkg::OP_INSERT, -32'sd1);
        send_word(mhpq_pkg::OP_INSERT, 32'sh0000_0001);
        send_word(mhpq_pkg::OP_INSERT, 32'sh8000_0000);
        send_word(mhpq_pkg::OP_INSERT, 32'sh5555_5555);
        send_word(mhpq_pkg::OP_INSERT, 32'shaaaa_aaaa);
        repeat (8) send_word(mhpq_pkg::OP_EXTRACT, 32'sh0000_0000);
        send_word(mhpq_pkg::OP_EXTRACT, -32'sd1);
        send_word(mhpq_pkg::OP_INSERT, 32'sh0000_0005);
        send_word(mhpq_pkg::OP_EXTRACT, 32'sh0000_0000);
        send_word(mhpq_pkg::OP_INSERT, 32'sh0000_0007);
        send_word(mhpq_pkg::OP_INSERT, 32'sh0000_0007);
        send_word(mhpq_pkg::OP_EXTRACT, 32'sh0000_0000);
        send_word(mhpq_pkg::OP_EXTRACT, 32'sh0000_0000);

        // Phase one: sender idles less than the receiver. Grow, shrink, wander.
        run_mix(60, 75);
        run_mix(60, 35);
        run_mix(60, 50);

        // Phase two: swap the idle rates.
        send_gap_pct = 58;
        recv_gap_pct = 31;
        run_mix(60, 75);
        run_mix(60, 35);
        run_mix(60, 50);

        // Phase three: no idling at all.
        send_gap_pct = 0;
        recv_gap_pct = 0;

        // Hold the receiver off for a long stretch while words keep coming, so
        // the output register backs up and the input stalls.
        recv_hold = 150;
        run_mix(30, 60);

        // Drain to empty, then extract from the empty queue again.
        while (shadow.fill > 0)
            send_word(mhpq_pkg::OP_EXTRACT, $urandom);
        run_mix(2, 0);
        run_mix(100, 55);

        in_valid <= 1'b0;

        // Wait for every expected reply, then watch a little longer for strays.
        while (shadow.due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d inserts (%0d refused as full) and %0d extracts (%0d on empty),",
                 shadow.inserts, shadow.full_refusals, shadow.extracts, shadow.empty_refusals);
        $display("peak depth %0d of %0d, %0d replies checked, %0d mismatches.",
                 shadow.peak, mhpq_pkg::CAPACITY, shadow.replies_seen, shadow.errors);
        if (shadow.errors == 0)
            $display("min_heap_priority_queue_tb OK");
        else
            $display("min_heap_priority_queue_tb NOT OK");
        $finish;
    end

endmodule
